@@ design/mmpd_pkg.sv @@
package mmpd_pkg;

  localparam int unsigned PULSES_PER_PACKET = 35;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned PACKET_W = 19;
  localparam int unsigned FAST_BIT = 10;

  localparam logic [1:0] CLASS_SHORT = 2'd0;
  localparam logic [1:0] CLASS_LONG = 2'd2;

  localparam logic [0:0] REG_OWN_ADDRESS = 1'd0;

  typedef struct packed {
    logic [5:0] pad;
    logic [3:0] speed_command;
    logic       address_match;
    logic [3:0] extra_data;
    logic [3:0] speed_data;
    logic       fast_packet;
    logic [1:0] function_bits;
    logic [7:0] decoded_address;
    logic       repeat_confirmed;
    logic       receiving;
  } result_t;

  localparam logic [7:0] ADDR_TABLE [256] = '{
    8'd80,  8'd2,   8'd81,  8'd1,   8'd6,   8'd8,   8'd82,  8'd7,
    8'd145, 8'd177, 8'd83,  8'd161, 8'd3,   8'd5,   8'd84,  8'd4,
    8'd18,  8'd20,  8'd85,  8'd19,  8'd24,  8'd26,  8'd86,  8'd25,
    8'd146, 8'd178, 8'd87,  8'd162, 8'd21,  8'd23,  8'd88,  8'd22,
    8'd193, 8'd201, 8'd89,  8'd197, 8'd217, 8'd225, 8'd90,  8'd221,
    8'd147, 8'd179, 8'd91,  8'd163, 8'd205, 8'd213, 8'd92,  8'd209,
    8'd9,   8'd11,  8'd93,  8'd10,  8'd15,  8'd17,  8'd94,  8'd16,
    8'd148, 8'd180, 8'd95,  8'd164, 8'd12,  8'd14,  8'd96,  8'd13,
    8'd54,  8'd56,  8'd97,  8'd55,  8'd60,  8'd62,  8'd98,  8'd61,
    8'd149, 8'd181, 8'd99,  8'd165, 8'd57,  8'd59,  8'd100, 8'd58,
    8'd72,  8'd74,  8'd101, 8'd73,  8'd78,  8'd0,   8'd102, 8'd79,
    8'd150, 8'd182, 8'd103, 8'd166, 8'd75,  8'd77,  8'd104, 8'd76,
    8'd194, 8'd202, 8'd105, 8'd198, 8'd218, 8'd226, 8'd106, 8'd222,
    8'd151, 8'd183, 8'd107, 8'd167, 8'd206, 8'd214, 8'd108, 8'd210,
    8'd63,  8'd65,  8'd109, 8'd64,  8'd69,  8'd71,  8'd110, 8'd70,
    8'd152, 8'd184, 8'd111, 8'd168, 8'd66,  8'd68,  8'd112, 8'd67,
    8'd229, 8'd231, 8'd113, 8'd230, 8'd235, 8'd237, 8'd114, 8'd236,
    8'd153, 8'd185, 8'd115, 8'd169, 8'd232, 8'd234, 8'd116, 8'd233,
    8'd247, 8'd249, 8'd117, 8'd255, 8'd248, 8'd253, 8'd118, 8'd254,
    8'd154, 8'd186, 8'd119, 8'd170, 8'd250, 8'd252, 8'd120, 8'd251,
    8'd195, 8'd203, 8'd121, 8'd199, 8'd219, 8'd227, 8'd122, 8'd223,
    8'd155, 8'd187, 8'd123, 8'd171, 8'd207, 8'd215, 8'd124, 8'd211,
    8'd238, 8'd240, 8'd125, 8'd239, 8'd244, 8'd246, 8'd126, 8'd245,
    8'd156, 8'd188, 8'd127, 8'd172, 8'd241, 8'd243, 8'd128, 8'd242,
    8'd27,  8'd29,  8'd129, 8'd28,  8'd33,  8'd35,  8'd130, 8'd34,
    8'd157, 8'd189, 8'd131, 8'd173, 8'd30,  8'd32,  8'd132, 8'd31,
    8'd45,  8'd47,  8'd133, 8'd46,  8'd51,  8'd53,  8'd134, 8'd52,
    8'd158, 8'd190, 8'd135, 8'd174, 8'd48,  8'd50,  8'd136, 8'd49,
    8'd196, 8'd204, 8'd137, 8'd200, 8'd220, 8'd228, 8'd138, 8'd224,
    8'd159, 8'd191, 8'd139, 8'd175, 8'd208, 8'd216, 8'd140, 8'd212,
    8'd36,  8'd38,  8'd141, 8'd37,  8'd42,  8'd44,  8'd142, 8'd43,
    8'd160, 8'd192, 8'd143, 8'd176, 8'd39,  8'd41,  8'd144, 8'd40
  };

  // packet bit number to position: address, function, then data/extra interleaved
  function automatic logic [4:0] bit_position(input logic [4:0] n);
    logic [4:0] m;
    m = n - 5'd10;
    if (n < 5'd10) begin
      return n;
    end else if (!m[0]) begin
      return 5'd11 + {1'b0, m[4:1]};
    end else begin
      return 5'd15 + {1'b0, m[4:1]};
    end
  endfunction

endpackage

@@ design/mm_pulse_packet_decoder.sv @@
// Motorola-format track packet decoder. Each input word is one classified pulse
// (s_tdata[1:0]: 0 short, 1 medium, 2 long; s_tuser: start of packet) and gives
// exactly one output word. The 35th pulse of a packet completes it; a completed
// packet identical to the previous one is a confirmed repeat, whose address bits
// are decoded through a fixed 256-entry table and compared with own_address; on a
// match the four speed bits are latched into speed_command. A pulse is accepted
// every cycle while the output side takes words: all decode work sits in one
// combinational stage in front of the output register, so a pulse's word is valid
// in the cycle after it is taken. own_address is written at byte address 0.
module mm_pulse_packet_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pulse_class[1:0], zero padding
  input  logic        s_tuser,   // packet_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // receiving, repeat_confirmed, decoded_address[7:0], function_bits[1:0],
  // fast_packet, speed_data[3:0], extra_data[3:0], address_match, speed_command[3:0]
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]                      own_address;
  logic [mmpd_pkg::PACKET_W-1:0]   packet_current;
  logic [mmpd_pkg::PACKET_W-1:0]   packet_current_next;
  logic [mmpd_pkg::PACKET_W-1:0]   packet_previous;
  logic [mmpd_pkg::PACKET_W-1:0]   packet_previous_next;
  logic [mmpd_pkg::COUNT_W-1:0]    pulse_count;
  logic [mmpd_pkg::COUNT_W-1:0]    pulse_count_next;
  logic [3:0]                      latched_speed;
  logic [3:0]                      latched_speed_next;
  mmpd_pkg::result_t               result;
  mmpd_pkg::result_t               result_next;

  logic                            accept;
  logic [1:0]                      pulse_class;
  logic [mmpd_pkg::COUNT_W-1:0]    count_base;
  logic [mmpd_pkg::COUNT_W-1:0]    count_inc;
  logic [mmpd_pkg::PACKET_W-1:0]   packet_build;
  logic [7:0]                      table_address;

  assign pready   = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = result;
  assign pulse_class = s_tdata[1:0];
  assign table_address = mmpd_pkg::ADDR_TABLE[packet_previous[7:0]];

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == mmpd_pkg::REG_OWN_ADDRESS) begin
      prdata = {24'd0, own_address};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2:2] == mmpd_pkg::REG_OWN_ADDRESS) begin
      own_address <= pwdata[7:0];
    end
  end

  always_comb begin
    count_base = s_tuser ? '0 : pulse_count;
    packet_build = s_tuser ? '0 : packet_current;
    count_inc = count_base + 1'b1;
    packet_current_next = packet_build;
    packet_previous_next = packet_previous;
    pulse_count_next = count_base;
    latched_speed_next = latched_speed;
    result_next = '0;

    if (count_base < mmpd_pkg::COUNT_W'(mmpd_pkg::PULSES_PER_PACKET)) begin
      if (!count_base[0] && pulse_class != mmpd_pkg::CLASS_SHORT) begin
        packet_build[mmpd_pkg::bit_position(count_base[5:1])] = 1'b1;
      end
      if (pulse_class == mmpd_pkg::CLASS_LONG) begin
        packet_build[mmpd_pkg::FAST_BIT] = 1'b1;
      end
      packet_current_next = packet_build;
      pulse_count_next = count_inc;
      if (count_inc == mmpd_pkg::COUNT_W'(mmpd_pkg::PULSES_PER_PACKET)) begin
        if (packet_build == packet_previous) begin
          result_next.repeat_confirmed = 1'b1;
          result_next.decoded_address = table_address;
          result_next.function_bits = packet_previous[9:8];
          result_next.fast_packet = packet_previous[mmpd_pkg::FAST_BIT];
          result_next.speed_data = packet_previous[14:11];
          result_next.extra_data = packet_previous[18:15];
          if (table_address == own_address) begin
            result_next.address_match = 1'b1;
            latched_speed_next = packet_previous[14:11];
          end
        end else begin
          packet_previous_next = packet_build;
        end
      end else begin
        result_next.receiving = 1'b1;
      end
    end
    result_next.speed_command = latched_speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_current <= '0;
      packet_previous <= '0;
      pulse_count <= '0;
      latched_speed <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        packet_current <= packet_current_next;
        packet_previous <= packet_previous_next;
        pulse_count <= pulse_count_next;
        latched_speed <= latched_speed_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pulse_count <= mmpd_pkg::COUNT_W'(mmpd_pkg::PULSES_PER_PACKET))
    else $error("pulse count beyond packet length");

  a_repeat_complete: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.repeat_confirmed |-> !result.receiving)
    else $error("repeat reported on incomplete packet");

  a_no_repeat_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result.repeat_confirmed |->
      result.decoded_address == 8'd0 && !result.address_match &&
      result.speed_data == 4'd0)
    else $error("decode fields set without repeat");

  a_match_latch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.address_match |->
      result.speed_command == result.speed_data &&
      latched_speed == result.speed_command)
    else $error("speed not latched on address match");
`endif

endmodule

@@ tb/sv/mm_pulse_packet_decoder_tb.sv @@
module mm_pulse_packet_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 140;
  localparam int STALL_LIMIT = 4000;

  // address bits to decoded address, entry 0 in the top byte
  localparam logic [2047:0] ADDR_LUT = {
    8'd80,  8'd2,   8'd81,  8'd1,   8'd6,   8'd8,   8'd82,  8'd7,
    8'd145, 8'd177, 8'd83,  8'd161, 8'd3,   8'd5,   8'd84,  8'd4,
    8'd18,  8'd20,  8'd85,  8'd19,  8'd24,  8'd26,  8'd86,  8'd25,
    8'd146, 8'd178, 8'd87,  8'd162, 8'd21,  8'd23,  8'd88,  8'd22,
    8'd193, 8'd201, 8'd89,  8'd197, 8'd217, 8'd225, 8'd90,  8'd221,
    8'd147, 8'd179, 8'd91,  8'd163, 8'd205, 8'd213, 8'd92,  8'd209,
    8'd9,   8'd11,  8'd93,  8'd10,  8'd15,  8'd17,  8'd94,  8'd16,
    8'd148, 8'd180, 8'd95,  8'd164, 8'd12,  8'd14,  8'd96,  8'd13,
    8'd54,  8'd56,  8'd97,  8'd55,  8'd60,  8'd62,  8'd98,  8'd61,
    8'd149, 8'd181, 8'd99,  8'd165, 8'd57,  8'd59,  8'd100, 8'd58,
    8'd72,  8'd74,  8'd101, 8'd73,  8'd78,  8'd0,   8'd102, 8'd79,
    8'd150, 8'd182, 8'd103, 8'd166, 8'd75,  8'd77,  8'd104, 8'd76,
    8'd194, 8'd202, 8'd105, 8'd198, 8'd218, 8'd226, 8'd106, 8'd222,
    8'd151, 8'd183, 8'd107, 8'd167, 8'd206, 8'd214, 8'd108, 8'd210,
    8'd63,  8'd65,  8'd109, 8'd64,  8'd69,  8'd71,  8'd110, 8'd70,
    8'd152, 8'd184, 8'd111, 8'd168, 8'd66,  8'd68,  8'd112, 8'd67,
    8'd229, 8'd231, 8'd113, 8'd230, 8'd235, 8'd237, 8'd114, 8'd236,
    8'd153, 8'd185, 8'd115, 8'd169, 8'd232, 8'd234, 8'd116, 8'd233,
    8'd247, 8'd249, 8'd117, 8'd255, 8'd248, 8'd253, 8'd118, 8'd254,
    8'd154, 8'd186, 8'd119, 8'd170, 8'd250, 8'd252, 8'd120, 8'd251,
    8'd195, 8'd203, 8'd121, 8'd199, 8'd219, 8'd227, 8'd122, 8'd223,
    8'd155, 8'd187, 8'd123, 8'd171, 8'd207, 8'd215, 8'd124, 8'd211,
    8'd238, 8'd240, 8'd125, 8'd239, 8'd244, 8'd246, 8'd126, 8'd245,
    8'd156, 8'd188, 8'd127, 8'd172, 8'd241, 8'd243, 8'd128, 8'd242,
    8'd27,  8'd29,  8'd129, 8'd28,  8'd33,  8'd35,  8'd130, 8'd34,
    8'd157, 8'd189, 8'd131, 8'd173, 8'd30,  8'd32,  8'd132, 8'd31,
    8'd45,  8'd47,  8'd133, 8'd46,  8'd51,  8'd53,  8'd134, 8'd52,
    8'd158, 8'd190, 8'd135, 8'd174, 8'd48,  8'd50,  8'd136, 8'd49,
    8'd196, 8'd204, 8'd137, 8'd200, 8'd220, 8'd228, 8'd138, 8'd224,
    8'd159, 8'd191, 8'd139, 8'd175, 8'd208, 8'd216, 8'd140, 8'd212,
    8'd36,  8'd38,  8'd141, 8'd37,  8'd42,  8'd44,  8'd142, 8'd43,
    8'd160, 8'd192, 8'd143, 8'd176, 8'd39,  8'd41,  8'd144, 8'd40
  };

  typedef struct packed {
    logic              set_own;
    logic [7:0]        own;
    logic [1:0]        cls;
    logic              start;
    logic [5:0]        len;
    logic              typed;
    mmpd_pkg::result_t val;
  } pulse_run_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // pulse_class[1:0], zero padding
  logic        s_tuser;   // packet_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // receiving, repeat_confirmed, decoded_address[7:0], function_bits[1:0],
  // fast_packet, speed_data[3:0], extra_data[3:0], address_match, speed_command[3:0]
  logic [31:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [18:0] pkt_cur;
  logic [18:0] pkt_prev;
  logic [5:0]  pulse_cnt;
  logic [3:0]  speed_latch;
  logic [7:0]  own_cfg;

  mmpd_pkg::result_t expected_words [$];
  mmpd_pkg::result_t exp_r;
  mmpd_pkg::result_t got;
  logic              cur_typed;
  mmpd_pkg::result_t cur_typed_val;
  logic              calm;
  int                errors;
  int                items_sent;
  int                ready_hold = 0;
  int                hold_pick;
  int                quiet_cycles = 0;

  mm_pulse_packet_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] mm_addr(logic [7:0] idx);
    return ADDR_LUT[8 * (255 - int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] addr_bits_for(logic [7:0] decoded);
    for (int i = 0; i < 256; i++) begin
      if (mm_addr(8'(i)) == decoded) begin
        return 8'(i);
      end
    end
    return 8'd0;
  endfunction

  // address, function, then data and extra data interleaved; bit 10 is the fast flag
  function automatic int pkt_bit_index(logic [4:0] n);
    if (n < 5'd10) begin
      return int'(n);
    end
    return (n[0] ? 15 : 11) + (int'(n) - 10) / 2;
  endfunction

  function automatic mmpd_pkg::result_t decode_pulse(logic [1:0] cls, logic start);
    mmpd_pkg::result_t r;
    r = '0;
    if (start) begin
      pkt_cur = '0;
      pulse_cnt = '0;
    end
    if (pulse_cnt < mmpd_pkg::PULSES_PER_PACKET) begin
      if (!pulse_cnt[0] && cls != mmpd_pkg::CLASS_SHORT) begin
        pkt_cur[pkt_bit_index(pulse_cnt[5:1])] = 1'b1;
      end
      if (cls == mmpd_pkg::CLASS_LONG) begin
        pkt_cur[mmpd_pkg::FAST_BIT] = 1'b1;
      end
      pulse_cnt = pulse_cnt + 6'd1;
      if (pulse_cnt == mmpd_pkg::PULSES_PER_PACKET) begin
        if (pkt_cur == pkt_prev) begin
          r.repeat_confirmed = 1'b1;
          r.decoded_address = mm_addr(pkt_prev[7:0]);
          r.function_bits = pkt_prev[9:8];
          r.fast_packet = pkt_prev[mmpd_pkg::FAST_BIT];
          r.speed_data = pkt_prev[14:11];
          r.extra_data = pkt_prev[18:15];
          if (r.decoded_address == own_cfg) begin
            r.address_match = 1'b1;
            speed_latch = r.speed_data;
          end
        end else begin
          pkt_prev = pkt_cur;
        end
      end else begin
        r.receiving = 1'b1;
      end
    end
    r.speed_command = speed_latch;
    return r;
  endfunction

  function automatic string fmt(mmpd_pkg::result_t r);
    return $sformatf({"rcv=%0d rep=%0d adr=%0d fn=%0d fast=%0d ",
                      "spd=%0d xtr=%0d mat=%0d cmd=%0d pad=%0h"},
                     r.receiving, r.repeat_confirmed, r.decoded_address, r.function_bits,
                     r.fast_packet, r.speed_data, r.extra_data, r.address_match,
                     r.speed_command, r.pad);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [1:0] any_class(logic allow_long);
    case ($urandom_range(0, allow_long ? 3 : 2))
      0: return mmpd_pkg::CLASS_SHORT;
      1: return CLASS_MEDIUM;
      2: return CLASS_UNUSED;
      default: return mmpd_pkg::CLASS_LONG;
    endcase
  endfunction

  function automatic pulse_run_t run(logic set_own, logic [7:0] own, logic [1:0] cls,
                                     logic start, logic [5:0] len, logic typed,
                                     mmpd_pkg::result_t val);
    pulse_run_t p;
    p.set_own = set_own;
    p.own = own;
    p.cls = cls;
    p.start = start;
    p.len = len;
    p.typed = typed;
    p.val = val;
    return p;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_own_address(logic [7:0] v);
    logic [31:0] rd;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write({mmpd_pkg::REG_OWN_ADDRESS, 2'b00}, {24'd0, v});
    own_cfg = v;
    @(posedge clk);
    apb_read({mmpd_pkg::REG_OWN_ADDRESS, 2'b00}, rd);
    if (rd !== {24'd0, v}) begin
      flag_error($sformatf("own_address readback: exp %0h got %0h", v, rd));
    end
  endtask

  task automatic send_pulse(logic [1:0] cls, logic start, logic typed,
                            mmpd_pkg::result_t tv);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, cls};
    s_tuser <= start;
    cur_typed <= typed;
    cur_typed_val <= tv;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // well-formed packet: set bits on even pulses, odd pulses any class, long only when the fast bit is set
  task automatic send_packet(logic [18:0] pkt);
    logic [1:0] c;
    for (int pos = 0; pos < mmpd_pkg::PULSES_PER_PACKET; pos++) begin
      if (pos % 2 == 0) begin
        if (!pkt[pkt_bit_index(5'(pos / 2))]) begin
          c = mmpd_pkg::CLASS_SHORT;
        end else if (pkt[mmpd_pkg::FAST_BIT] && $urandom_range(0, 2) == 0) begin
          c = mmpd_pkg::CLASS_LONG;
        end else begin
          c = $urandom_range(0, 1) ? CLASS_MEDIUM : CLASS_UNUSED;
        end
      end else if (pos == 1 && pkt[mmpd_pkg::FAST_BIT]) begin
        c = mmpd_pkg::CLASS_LONG;
      end else begin
        c = any_class(pkt[mmpd_pkg::FAST_BIT]);
      end
      send_pulse(c, pos == 0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pkt_cur = '0;
      pkt_prev = '0;
      pulse_cnt = '0;
      speed_latch = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        exp_r = decode_pulse(s_tdata[1:0], s_tuser);
        if (cur_typed) begin
          exp_r = cur_typed_val;
        end
        expected_words.push_back(exp_r);
      end
      if (m_tvalid && m_tready) begin
        got = mmpd_pkg::result_t'(m_tdata);
        if (expected_words.size() == 0) begin
          flag_error($sformatf("unexpected word: %s", fmt(got)));
        end else begin
          exp_r = expected_words.pop_front();
          if (got !== exp_r) begin
            flag_error($sformatf("mismatch: exp %s", fmt(exp_r)));
            if (errors <= 10) begin
              $display("          got %s", fmt(got));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      hold_pick = pick_gap();
      m_tready <= (hold_pick == 0);
      ready_hold <= (hold_pick > 0) ? hold_pick - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stim
    pulse_run_t        runs [$];
    pulse_run_t        cur;
    mmpd_pkg::result_t rcv_only;
    mmpd_pkg::result_t rep_zero;
    logic [7:0]        addr_pool [4];
    logic [18:0]       last_pkt;
    logic [18:0]       pkt;
    logic [7:0]        own;
    int                phase_end;
    int                r;
    int                n;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_typed = 1'b0;
    cur_typed_val = '0;
    calm = 1'b0;
    errors = 0;
    items_sent = 0;
    own_cfg = '0;

    rcv_only = '0;
    rcv_only.receiving = 1'b1;
    rep_zero = '0;
    rep_zero.repeat_confirmed = 1'b1;
    rep_zero.decoded_address = 8'd80;

    // pulse before any start, all-short repeat, pulses after completion
    runs.push_back(run(1'b1, 8'd0, CLASS_MEDIUM, 1'b0, 6'd1, 1'b1, rcv_only));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_SHORT, 1'b1, 6'd34, 1'b1, rcv_only));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_SHORT, 1'b0, 6'd1, 1'b1, rep_zero));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_LONG, 1'b0, 6'd3, 1'b1, '0));
    // all-medium, all-long and class three packets, each sent twice; an abandoned class three packet sits in between
    runs.push_back(run(1'b0, 8'd0, CLASS_MEDIUM, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, CLASS_MEDIUM, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_LONG, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_LONG, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, CLASS_UNUSED, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, CLASS_UNUSED, 1'b1, 6'd10, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, CLASS_UNUSED, 1'b1, 6'd35, 1'b0, '0));
    // matching repeat latches speed; then an all-short repeat that does not match own address
    runs.push_back(run(1'b1, 8'd40, CLASS_MEDIUM, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_LONG, 1'b0, 6'd2, 1'b0, '0));
    runs.push_back(run(1'b1, 8'd255, mmpd_pkg::CLASS_SHORT, 1'b1, 6'd35, 1'b0, '0));
    runs.push_back(run(1'b0, 8'd0, mmpd_pkg::CLASS_SHORT, 1'b1, 6'd35, 1'b0, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (runs[i]) begin
      cur = runs[i];
      if (cur.set_own) begin
        set_own_address(cur.own);
      end
      for (int k = 0; k < cur.len; k++) begin
        send_pulse(cur.cls, cur.start && k == 0, cur.typed, cur.val);
      end
    end

    last_pkt = '0;
    for (int p = 0; p < PHASES; p++) begin
      own = (p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'($urandom_range(0, 255));
      set_own_address(own);
      calm = (p % 4 == 3);
      addr_pool[0] = addr_bits_for(own);
      for (int j = 1; j < 4; j++) begin
        addr_pool[j] = 8'($urandom_range(0, 255));
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 99) < 55) begin
            pkt = last_pkt;
          end else begin
            pkt = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 2) == 0), 2'($urandom_range(0, 3)),
                   ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255))};
          end
          send_packet(pkt);
          last_pkt = pkt;
          if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
              send_pulse(any_class(1'b1), 1'b0, 1'b0, '0);
            end
          end
        end else if (r < 85) begin
          // abandoned packet
          n = $urandom_range(1, 34);
          for (int k = 0; k < n; k++) begin
            send_pulse(any_class(1'b1), k == 0, 1'b0, '0);
          end
        end else begin
          n = $urandom_range(1, 8);
          for (int k = 0; k < n; k++) begin
            send_pulse(any_class(1'b1), $urandom_range(0, 4) == 0, 1'b0, '0);
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mmpd_pkg.sv
design/mm_pulse_packet_decoder.sv
tb/sv/mm_pulse_packet_decoder_tb.sv
